// ===== sv/qrs_peak_decision_search_back_defines.svh =====
// Assertion helpers shared by the checking code of the peak decision block
`ifndef QRS_PEAK_DECISION_SEARCH_BACK_DEFINES_SVH
`define QRS_PEAK_DECISION_SEARCH_BACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define QRSPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define QRSPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/qrspd_pkg.sv =====
package qrspd_pkg;

	localparam int MED_W     = 32;
	localparam int MED_CNT_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF      = 1'b1;

	// 0.3 in unsigned Q1.16
	localparam logic [16:0] POINT3_Q16 = 17'd19661;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_MED_START,
		S_MED_RUN,
		S_SEED_MUL,
		S_SEED_DT,
		S_JUDGE,
		S_SB_CHECK,
		S_THR_MUL,
		S_THR_DT,
		S_THR_SB_MUL,
		S_THR_SB,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_SEED,
		PH_NOISE_INIT,
		PH_DETECT
	} phase_t;

	typedef enum logic [1:0] {
		SRC_SIG,
		SRC_NOI,
		SRC_RR
	} med_src_t;

	typedef struct packed {
		logic                 start;
		logic [MED_CNT_W-1:0] n;
	} med_ctl_t;

	typedef struct packed {
		logic             done;
		logic [MED_W-1:0] result;
	} med_sts_t;

endpackage

// ===== sv/qrspd_cfg_if.sv =====
interface qrspd_cfg_if import qrspd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/qrspd_peak_if.sv =====
interface qrspd_peak_if ();
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] peak_position;
	logic [15:0] peak_height;

	modport source (output valid, kind, peak_position, peak_height, input ready);
	modport sink (input valid, kind, peak_position, peak_height, output ready);
endinterface

// ===== sv/qrspd_beat_if.sv =====
interface qrspd_beat_if ();
	logic        valid;
	logic        ready;
	logic [31:0] beat_position;
	logic [15:0] beat_height;
	logic        from_search_back;

	modport source (output valid, beat_position, beat_height, from_search_back, input ready);
	modport sink (input valid, beat_position, beat_height, from_search_back, output ready);
endinterface

// ===== sv/qrspd_median.sv =====
// Rank-select median: one candidate entry per cycle is ranked against the
// first n entries in parallel.
module qrspd_median import qrspd_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  med_ctl_t         ctl,
	input  logic [MED_W-1:0] vals [DEPTH],
	output med_sts_t         sts
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    n_q;
	logic [MED_W-1:0] m1_q;
	logic [MED_W-1:0] m2_q;

	logic [MED_W-1:0] cand;
	logic [CW-1:0]    lt;
	logic [CW-1:0]    le;
	logic [CW-1:0]    k1;
	logic [CW-1:0]    k2;
	logic [MED_W:0]   sum;

	// rank the current candidate
	always_comb begin
		cand = vals[i_q[IW-1:0]];
		lt   = '0;
		le   = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (CW'(j) < n_q) begin
				if (vals[j] < cand)
					lt = lt + CW'(1);
				if (vals[j] <= cand)
					le = le + CW'(1);
			end
		end
		k1 = (n_q - CW'(1)) >> 1;
		k2 = n_q >> 1;
	end

	// step through candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				n_q <= CW'(ctl.n);
				i_q <= '0;
				if (ctl.n == '0)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				i_q <= i_q + CW'(1);
				if (i_q == n_q - CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// capture the middle entries
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			m1_q <= '0;
			m2_q <= '0;
		end else if (busy_q) begin
			if (lt <= k1 && k1 < le)
				m1_q <= cand;
			if (lt <= k2 && k2 < le)
				m2_q <= cand;
		end
	end

	assign sum        = {1'b0, m1_q} + {1'b0, m2_q};
	assign sts.done   = done_q;
	assign sts.result = sum[MED_W:1];

endmodule

// ===== sv/qrs_peak_decision_search_back.sv =====
// Channel | Dir | Payload
// cfg     | in  | index (0 refractory_samples, 1 threshold_coeff), data
// peak    | in  | kind, peak_position, peak_height
// beat    | out | beat_position, beat_height, from_search_back
//
// Each item runs from acceptance until peak.ready returns through the
// sequencer steps, one registered multiplier pass per product and one median
// per refreshed history on the shared rank-select unit, plus any wait in the
// output step. peak.ready is high only while the sequencer is idle. A held
// result does not block the next item; the sequencer waits only when a new
// result meets a result not yet taken.
// Reset clears all control state at once; histories need no clearing.
module qrs_peak_decision_search_back import qrspd_pkg::*; #(
	parameter int PEAK_HISTORY = 10,
	parameter int RR_HISTORY   = 8
) (
	input logic          clk,
	input logic          arst_n,
	qrspd_cfg_if.sink    cfg,
	qrspd_peak_if.sink   peak,
	qrspd_beat_if.source beat
);

	`include "qrs_peak_decision_search_back_defines.svh"

	localparam int MD  = (PEAK_HISTORY > RR_HISTORY) ? PEAK_HISTORY : RR_HISTORY;
	localparam int PW  = $clog2(PEAK_HISTORY);
	localparam int RW  = $clog2(RR_HISTORY);
	localparam int PFW = $clog2(PEAK_HISTORY + 1);
	localparam int RFW = $clog2(RR_HISTORY + 1);

	// configuration
	logic [15:0] refr_q;
	logic [15:0] coeff_q;

	// control and state
	state_t      state_q, state_d;
	state_t      after_q, after_d;
	state_t      thr_ret_q, thr_ret_d;
	phase_t      phase_q;
	med_src_t    src_q;
	logic [2:0]  pend_q, pend_d;

	logic        kind_q;
	logic [31:0] pos_q;
	logic [15:0] h_q;

	logic [15:0] sig_q [PEAK_HISTORY];
	logic [15:0] noi_q [PEAK_HISTORY];
	logic [31:0] rr_q  [RR_HISTORY];
	logic [PW-1:0]  sig_wr_q, noi_wr_q;
	logic [RW-1:0]  rr_wr_q;
	logic [PFW-1:0] sig_fill_q, noi_fill_q;
	logic [RFW-1:0] rr_fill_q;

	logic [31:0] last_q;
	logic [15:0] sig_lvl_q;
	logic [15:0] noi_lvl_q;
	logic [23:0] dt_q;
	logic [23:0] sb_q;
	logic [33:0] limit_q;
	logic [15:0] best_h_q;
	logic [31:0] best_pos_q;

	logic        emit_q;
	logic [31:0] stg_pos_q;
	logic [15:0] stg_h_q;
	logic        stg_sb_q;
	logic [31:0] o_pos_q;
	logic [15:0] o_h_q;
	logic        o_sb_q;
	logic        bvalid_q;

	logic signed [41:0] prod_q;
	logic signed [41:0] prod_d;

	// sequencer outputs
	logic        push_sig, push_noi, push_rr;
	logic [15:0] push_sig_v, push_noi_v;
	logic [31:0] push_rr_v;
	logic        set_last;
	logic [31:0] last_v;
	logic        stage_out;
	logic [31:0] stage_pos;
	logic [15:0] stage_h;
	logic        stage_sb;
	logic        clr_best, set_best;
	logic        load_beat;

	med_ctl_t         med_ctl;
	med_sts_t         med_sts;
	med_src_t         src_d;
	logic [MED_W-1:0] med_vals [MD];

	logic signed [24:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [41:0] t_sum;

	logic [31:0] gap;
	logic [23:0] h_x;
	logic        gap_gt_ref;
	logic        beat_ok;
	logic        sb_fire;

	assign gap        = pos_q - last_q;
	assign h_x        = {h_q, 8'b0};
	assign gap_gt_ref = !gap[31] && (gap > {16'b0, refr_q});
	assign beat_ok    = (h_x > dt_q) && gap_gt_ref;
	assign sb_fire    = (best_h_q != '0) && !gap[31] && (gap != '0)
		&& ({1'b0, gap, 1'b0} > limit_q);
	assign t_sum      = $signed({10'b0, noi_lvl_q, 16'b0}) + prod_q;
	assign prod_d     = mul_a * mul_b;

	assign cfg.ready  = 1'b1;
	assign peak.ready = (state_q == S_IDLE);

	assign beat.valid            = bvalid_q;
	assign beat.beat_position    = o_pos_q;
	assign beat.beat_height      = o_h_q;
	assign beat.from_search_back = o_sb_q;

	// feed the median unit from the selected history
	always_comb begin
		for (int k = 0; k < MD; k++) begin
			med_vals[k] = '0;
			case (src_q)
				SRC_SIG: if (k < PEAK_HISTORY) med_vals[k] = {16'b0, sig_q[k]};
				SRC_NOI: if (k < PEAK_HISTORY) med_vals[k] = {16'b0, noi_q[k]};
				SRC_RR:  if (k < RR_HISTORY) med_vals[k] = rr_q[k];
				default: med_vals[k] = '0;
			endcase
		end
	end

	// select multiplier operands
	always_comb begin
		case (state_q)
			S_THR_MUL: begin
				mul_a = 25'($signed({1'b0, sig_lvl_q}) - $signed({1'b0, noi_lvl_q}));
				mul_b = $signed({1'b0, coeff_q});
			end
			S_THR_SB_MUL: begin
				mul_a = $signed({1'b0, dt_q});
				mul_b = $signed(POINT3_Q16);
			end
			default: begin
				mul_a = $signed({9'b0, sig_lvl_q});
				mul_b = $signed(POINT3_Q16);
			end
		endcase
	end

	// next state and sequencer actions
	always_comb begin
		state_d    = state_q;
		after_d    = after_q;
		thr_ret_d  = thr_ret_q;
		pend_d     = pend_q;
		src_d      = src_q;
		push_sig   = 1'b0;
		push_noi   = 1'b0;
		push_rr    = 1'b0;
		push_sig_v = h_q;
		push_noi_v = h_q;
		push_rr_v  = gap;
		set_last   = 1'b0;
		last_v     = pos_q;
		stage_out  = 1'b0;
		stage_pos  = pos_q;
		stage_h    = h_q;
		stage_sb   = 1'b0;
		clr_best   = 1'b0;
		set_best   = 1'b0;
		load_beat  = 1'b0;
		med_ctl    = '0;
		case (state_q)
			S_IDLE: begin
				if (peak.valid)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				case (phase_q)
					PH_SEED: begin
						if (kind_q) begin
							state_d = S_IDLE;
						end else begin
							push_sig  = 1'b1;
							set_last  = 1'b1;
							stage_out = 1'b1;
							state_d   = S_MED_START;
							if (sig_fill_q != '0) begin
								push_rr = 1'b1;
								pend_d  = 3'b101;
								after_d = S_SEED_MUL;
							end else begin
								pend_d  = 3'b001;
								after_d = S_OUT;
							end
						end
					end
					PH_NOISE_INIT: begin
						if (!kind_q) begin
							state_d = S_IDLE;
						end else if (gap[31]) begin
							push_noi = (h_x < dt_q);
							state_d  = S_IDLE;
						end else begin
							pend_d    = 3'b010;
							after_d   = S_THR_MUL;
							thr_ret_d = S_JUDGE;
							state_d   = S_MED_START;
						end
					end
					default: begin
						state_d = kind_q ? S_JUDGE : S_IDLE;
					end
				endcase
			end
			S_JUDGE: begin
				state_d = S_MED_START;
				if (beat_ok) begin
					push_sig  = 1'b1;
					push_rr   = 1'b1;
					set_last  = 1'b1;
					stage_out = 1'b1;
					clr_best  = 1'b1;
					pend_d    = 3'b101;
					after_d   = S_THR_MUL;
					thr_ret_d = S_OUT;
				end else begin
					push_noi = 1'b1;
					set_best = (h_q > best_h_q) && (h_x > sb_q) && gap_gt_ref;
					pend_d   = 3'b010;
					after_d  = S_SB_CHECK;
				end
			end
			S_SB_CHECK: begin
				thr_ret_d = S_OUT;
				if (sb_fire) begin
					push_sig   = 1'b1;
					push_sig_v = best_h_q;
					push_rr    = 1'b1;
					push_rr_v  = best_pos_q - last_q;
					set_last   = 1'b1;
					last_v     = best_pos_q;
					stage_out  = 1'b1;
					stage_pos  = best_pos_q;
					stage_h    = best_h_q;
					stage_sb   = 1'b1;
					clr_best   = 1'b1;
					pend_d     = 3'b101;
					after_d    = S_THR_MUL;
					state_d    = S_MED_START;
				end else begin
					state_d = S_THR_MUL;
				end
			end
			S_MED_START: begin
				if (pend_q == '0) begin
					state_d = after_q;
				end else begin
					med_ctl.start = 1'b1;
					state_d       = S_MED_RUN;
					if (pend_q[0]) begin
						src_d     = SRC_SIG;
						med_ctl.n = MED_CNT_W'(sig_fill_q);
					end else if (pend_q[1]) begin
						src_d     = SRC_NOI;
						med_ctl.n = MED_CNT_W'(noi_fill_q);
					end else begin
						src_d     = SRC_RR;
						med_ctl.n = MED_CNT_W'(rr_fill_q);
					end
				end
			end
			S_MED_RUN: begin
				if (med_sts.done) begin
					pend_d[src_q] = 1'b0;
					state_d       = S_MED_START;
				end
			end
			S_SEED_MUL:   state_d = S_SEED_DT;
			S_SEED_DT:    state_d = S_OUT;
			S_THR_MUL:    state_d = S_THR_DT;
			S_THR_DT:     state_d = S_THR_SB_MUL;
			S_THR_SB_MUL: state_d = S_THR_SB;
			S_THR_SB:     state_d = thr_ret_q;
			S_OUT: begin
				if (!emit_q) begin
					state_d = S_IDLE;
				end else if (!bvalid_q || beat.ready) begin
					load_beat = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			after_q   <= S_IDLE;
			thr_ret_q <= S_IDLE;
			pend_q    <= '0;
			src_q     <= SRC_SIG;
		end else begin
			state_q   <= state_d;
			after_q   <= after_d;
			thr_ret_q <= thr_ret_d;
			pend_q    <= pend_d;
			src_q     <= src_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_q  <= 16'd72;
			coeff_q <= 16'd8716;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_REFRACTORY: refr_q  <= cfg.data;
				REG_COEFF:      coeff_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (peak.valid && peak.ready) begin
			kind_q <= peak.kind;
			pos_q  <= peak.peak_position;
			h_q    <= peak.peak_height;
		end
	end

	// history stores
	always_ff @(posedge clk) begin
		if (push_sig)
			sig_q[sig_wr_q] <= push_sig_v;
		if (push_noi)
			noi_q[noi_wr_q] <= push_noi_v;
		if (push_rr)
			rr_q[rr_wr_q] <= push_rr_v;
	end

	// history pointers and fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_wr_q   <= '0;
			noi_wr_q   <= '0;
			rr_wr_q    <= '0;
			sig_fill_q <= '0;
			noi_fill_q <= '0;
			rr_fill_q  <= '0;
		end else begin
			if (push_sig) begin
				sig_wr_q <= (sig_wr_q == PW'(PEAK_HISTORY - 1)) ? '0 : sig_wr_q + PW'(1);
				if (sig_fill_q != PFW'(PEAK_HISTORY))
					sig_fill_q <= sig_fill_q + PFW'(1);
			end
			if (push_noi) begin
				noi_wr_q <= (noi_wr_q == PW'(PEAK_HISTORY - 1)) ? '0 : noi_wr_q + PW'(1);
				if (noi_fill_q != PFW'(PEAK_HISTORY))
					noi_fill_q <= noi_fill_q + PFW'(1);
			end
			if (push_rr) begin
				rr_wr_q <= (rr_wr_q == RW'(RR_HISTORY - 1)) ? '0 : rr_wr_q + RW'(1);
				if (rr_fill_q != RFW'(RR_HISTORY))
					rr_fill_q <= rr_fill_q + RFW'(1);
			end
		end
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	// levels, thresholds, beat bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEED;
			last_q     <= '0;
			sig_lvl_q  <= '0;
			noi_lvl_q  <= '0;
			dt_q       <= '0;
			sb_q       <= '0;
			limit_q    <= '0;
			best_h_q   <= '0;
			best_pos_q <= '0;
			emit_q     <= 1'b0;
		end else begin
			if (state_q == S_EVAL)
				emit_q <= 1'b0;
			if (stage_out)
				emit_q <= 1'b1;
			if (set_last)
				last_q <= last_v;
			if (clr_best) begin
				best_h_q   <= '0;
				best_pos_q <= '0;
			end else if (set_best) begin
				best_h_q   <= h_q;
				best_pos_q <= pos_q;
			end
			if (state_q == S_EVAL && phase_q == PH_NOISE_INIT && kind_q && !gap[31])
				phase_q <= PH_DETECT;
			if (state_q == S_MED_RUN && med_sts.done) begin
				case (src_q)
					SRC_SIG: sig_lvl_q <= med_sts.result[15:0];
					SRC_NOI: noi_lvl_q <= med_sts.result[15:0];
					default: limit_q <= {1'b0, med_sts.result, 1'b0} + {2'b0, med_sts.result};
				endcase
			end
			if (state_q == S_SEED_DT) begin
				dt_q    <= prod_q[31:8];
				phase_q <= PH_NOISE_INIT;
			end
			if (state_q == S_THR_DT)
				dt_q <= t_sum[41] ? '0 : t_sum[31:8];
			if (state_q == S_THR_SB)
				sb_q <= prod_q[39:16];
		end
	end

	// stage the result payload until the output is free
	always_ff @(posedge clk) begin
		if (stage_out) begin
			stg_pos_q <= stage_pos;
			stg_h_q   <= stage_h;
			stg_sb_q  <= stage_sb;
		end
	end

	// output payload: hold while a result waits
	always_ff @(posedge clk) begin
		if (load_beat) begin
			o_pos_q <= stg_pos_q;
			o_h_q   <= stg_h_q;
			o_sb_q  <= stg_sb_q;
		end
	end

	// output valid: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bvalid_q <= 1'b0;
		else if (load_beat)
			bvalid_q <= 1'b1;
		else if (beat.ready)
			bvalid_q <= 1'b0;
	end

	qrspd_median #(
		.DEPTH(MD)
	) u_median (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (med_ctl),
		.vals  (med_vals),
		.sts   (med_sts)
	);

	`QRSPD_ASSERT_NXT(a_accept_to_eval, peak.valid && peak.ready, state_q == S_EVAL, "item not taken to evaluation")
	`QRSPD_ASSERT_IMP(a_med_done_in_run, med_sts.done, state_q == S_MED_RUN, "median done outside run")
	`QRSPD_ASSERT_IMP(a_fill_bound, 1'b1, sig_fill_q <= PFW'(PEAK_HISTORY) && rr_fill_q <= RFW'(RR_HISTORY), "history fill overrun")
	`QRSPD_ASSERT_IMP(a_load_only_free, load_beat, !bvalid_q || beat.ready, "result overwritten before taken")

endmodule

// ===== dv/tb_qrs_beat_tracker.sv =====
import qrspd_pkg::*;

typedef struct {
	logic [31:0] position;
	logic [15:0] height;
	logic        search_back;
} beat_t;

// Tracks expected beats against those the block hands out
class beat_tracker;
	beat_t pending[$];
	int    fail_count;

	// Queue a beat predicted for an accepted peak
	function void note_peak(beat_t b);
		pending.push_back(b);
	endfunction

	// Compare a delivered beat with the oldest prediction; return 1 on a mismatch, else 0
	function int check_beat(beat_t got, ref string msg);
		beat_t w;
		if (pending.size() == 0) begin
			msg = $sformatf("unexpected beat pos=%0d h=%0d sb=%0d",
				got.position, got.height, got.search_back);
			return 1;
		end
		w = pending.pop_front();
		if (got.position !== w.position || got.height !== w.height
				|| got.search_back !== w.search_back) begin
			msg = $sformatf("beat got pos=%0d h=%0d sb=%0d want pos=%0d h=%0d sb=%0d",
				got.position, got.height, got.search_back,
				w.position, w.height, w.search_back);
			return 1;
		end
		return 0;
	endfunction
endclass

// ===== dv/tb.sv =====
module tb;
	import qrspd_pkg::*;

	localparam int PEAK_DEPTH = 10;
	localparam int RR_DEPTH   = 8;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qrspd_cfg_if  cfg ();
	qrspd_peak_if peak ();
	qrspd_beat_if beat ();

	qrs_peak_decision_search_back DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg.sink),
		.peak  (peak.sink),
		.beat  (beat.source)
	);

	always #6 clk = ~clk;

	beat_tracker tracker = new();
	int  error_count;
	int  idle_cycles;
	bit  quiet;
	bit  sink_stall_on = 1'b1;

	// Predictor state
	logic [15:0] refr_gap, coeff;
	logic [15:0] sig_hist[PEAK_DEPTH], noi_hist[PEAK_DEPTH];
	logic [31:0] rr_hist[RR_DEPTH];
	int unsigned sig_cnt, noi_cnt, rr_cnt;
	logic [31:0] last_pos, best_pos;
	logic [15:0] sig_lvl, noi_lvl, best_h;
	logic [23:0] det_thr, sb_thr;
	logic [33:0] rr_limit;
	phase_t      cur_phase;

	task automatic report(string msg);
		error_count++;
		$display("MISMATCH: %s", msg);
	endtask

	function automatic logic [31:0] median_of(logic [31:0] v[$]);
		logic [31:0] s[$];
		longint unsigned sum;
		s = v;
		s.sort();
		if (s.size() == 0) return 0;
		if (s.size() % 2) return s[s.size() / 2];
		sum = longint'(s[s.size() / 2 - 1]) + longint'(s[s.size() / 2]);
		return 32'(sum >> 1);
	endfunction

	function automatic logic [15:0] height_median(ref logic [15:0] a[PEAK_DEPTH],
			input int unsigned c);
		logic [31:0] v[$];
		int n;
		n = c < PEAK_DEPTH ? c : PEAK_DEPTH;
		for (int i = 0; i < n; i++) v.push_back(a[i]);
		return 16'(median_of(v));
	endfunction

	function automatic void push_height(ref logic [15:0] a[PEAK_DEPTH], ref int unsigned c,
			input logic [15:0] h);
		a[c % PEAK_DEPTH] = h;
		c++;
		if (c >= 2 * PEAK_DEPTH) c = PEAK_DEPTH;
	endfunction

	function automatic void push_interval(logic [31:0] iv);
		logic [31:0] v[$];
		int n;
		rr_hist[rr_cnt % RR_DEPTH] = iv;
		rr_cnt++;
		if (rr_cnt >= 2 * RR_DEPTH) rr_cnt = RR_DEPTH;
		n = rr_cnt < RR_DEPTH ? rr_cnt : RR_DEPTH;
		for (int i = 0; i < n; i++) v.push_back(rr_hist[i]);
		rr_limit = 34'd3 * median_of(v);
	endfunction

	function automatic void add_signal(logic [15:0] h);
		push_height(sig_hist, sig_cnt, h);
		sig_lvl = height_median(sig_hist, sig_cnt);
	endfunction

	function automatic void refresh_thresholds();
		longint t;
		t = longint'(noi_lvl) * 65536
			+ (longint'(sig_lvl) - longint'(noi_lvl)) * longint'(coeff);
		if (t < 0) t = 0;
		det_thr = 24'(t >> 8);
		sb_thr = 24'((longint'(det_thr) * POINT3_Q16) >> 16);
	endfunction

	function automatic longint signed_gap(logic [31:0] p, logic [31:0] from);
		logic [31:0] d;
		d = p - from;
		return longint'($signed(d));
	endfunction

	function automatic void reset_model();
		refr_gap = 16'd72; coeff = 16'd8716;
		sig_cnt = 0; noi_cnt = 0; rr_cnt = 0;
		last_pos = 0; sig_lvl = 0; noi_lvl = 0;
		det_thr = 0; sb_thr = 0; rr_limit = 0;
		best_h = 0; best_pos = 0;
		cur_phase = PH_SEED;
	endfunction

	// Work out the beat, if any, that a peak produces
	function automatic void classify_peak(logic k, logic [31:0] p, logic [15:0] h);
		beat_t b;
		longint g;
		logic [23:0] ht;
		ht = {h, 8'd0};
		if (cur_phase == PH_SEED) begin
			if (k) return;
			add_signal(h);
			if (sig_cnt >= 2) begin
				push_interval(p - last_pos);
				det_thr = 24'(((longint'(sig_lvl) << 8) * POINT3_Q16) >> 16);
				cur_phase = PH_NOISE_INIT;
			end
			last_pos = p;
			b.position = p; b.height = h; b.search_back = 0;
			tracker.note_peak(b);
			return;
		end
		if (!k) return;
		if (cur_phase == PH_NOISE_INIT) begin
			if (signed_gap(p, last_pos) < 0) begin
				if (ht < det_thr) push_height(noi_hist, noi_cnt, h);
				return;
			end
			noi_lvl = height_median(noi_hist, noi_cnt);
			refresh_thresholds();
			cur_phase = PH_DETECT;
		end
		g = signed_gap(p, last_pos);
		if (ht > det_thr && g > longint'(refr_gap)) begin
			add_signal(h);
			b.position = p; b.height = h; b.search_back = 0;
			tracker.note_peak(b);
			best_h = 0; best_pos = 0;
			push_interval(g[31:0]);
			last_pos = p;
		end else begin
			push_height(noi_hist, noi_cnt, h);
			noi_lvl = height_median(noi_hist, noi_cnt);
			if (h > best_h && ht > sb_thr && g > longint'(refr_gap)) begin
				best_h = h; best_pos = p;
			end
		end
		g = signed_gap(p, last_pos);
		if (best_h != 0 && g > 0 && longint'(rr_limit) < 2 * g) begin
			add_signal(best_h);
			b.position = best_pos; b.height = best_h; b.search_back = 1;
			tracker.note_peak(b);
			push_interval(best_pos - last_pos);
			last_pos = best_pos;
			best_h = 0; best_pos = 0;
		end
		refresh_thresholds();
	endfunction

	// Random idle burst on the sender side
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 18)) @(negedge clk);
	endtask

	task automatic send_peak(logic k, logic [31:0] p, logic [15:0] h);
		sender_gap();
		peak.valid = 1'b1;
		peak.kind = k;
		peak.peak_position = p;
		peak.peak_height = h;
		do @(posedge clk); while (!peak.ready);
		classify_peak(k, p, h);
		@(negedge clk);
		peak.valid = 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = v;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_REFRACTORY) refr_gap = v;
		else coeff = v;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Wait until every predicted beat has come, then let the block settle
	task automatic drain();
		while (tracker.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Reset the predictor history by sending a fresh pair of seeds is impossible;
	// instead a new record starts only once per run, so settings change mid-record.
	task automatic beat_train(int n_beats, int base_rr, logic [15:0] amp,
			ref logic [31:0] pos);
		int noise_n;
		for (int i = 0; i < n_beats; i++) begin
			noise_n = $urandom_range(0, 3);
			for (int j = 0; j < noise_n; j++)
				send_peak(1'b1, pos + 32'($urandom_range(1, base_rr - 1)),
					16'($urandom_range(0, amp / 4)));
			case ($urandom_range(0, 9))
				0: pos += 32'(base_rr * 2 + $urandom_range(0, base_rr));
				1: send_peak(1'b0, pos, 16'($urandom));
				2: send_peak(1'b1, pos + 32'($urandom_range(1, 40)), 16'($urandom));
				default: pos += 32'(base_rr + $urandom_range(0, base_rr / 4) - base_rr / 8);
			endcase
			send_peak(1'b1, pos, $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 65535))
				: 16'(amp - $urandom_range(0, amp / 5)));
		end
	endtask

	// Check delivered beats
	always @(posedge clk) begin
		string msg;
		beat_t got;
		if (arst_n && beat.valid && beat.ready) begin
			got.position = beat.beat_position;
			got.height = beat.beat_height;
			got.search_back = beat.from_search_back;
			if (tracker.check_beat(got, msg)) report(msg);
		end
	end

	// Receiver stalls in random bursts
	initial begin
		beat.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!sink_stall_on || quiet) beat.ready <= 1'b1;
			else if ($urandom_range(0, 5) == 0) begin
				beat.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				beat.ready <= 1'b1;
			end else beat.ready <= 1'b1;
		end
	end

	// Watchdog on accepted items
	always @(posedge clk) begin
		if ((peak.valid && peak.ready) || (beat.valid && beat.ready)
				|| (cfg.valid && cfg.ready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		logic [31:0] pos;
		peak.valid = 1'b0; peak.kind = 1'b0; peak.peak_position = '0; peak.peak_height = '0;
		cfg.valid = 1'b0; cfg.index = REG_REFRACTORY; cfg.data = '0;
		reset_model();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Configuration at idle: refractory 1, maximum coefficient, then the reset values again
		write_reg(REG_REFRACTORY, 16'd1);
		write_reg(REG_COEFF, 16'hFFFF);
		write_reg(REG_REFRACTORY, 16'd72);
		write_reg(REG_COEFF, 16'd8716);

		// Directed: out-of-place candidate, seeds, early noise, extremes
		pos = 32'hFFFF_FF00;
		send_peak(1'b1, 32'd5, 16'hFFFF);
		send_peak(1'b0, pos, 16'd3000);
		send_peak(1'b1, pos + 100, 16'd50);
		send_peak(1'b1, pos + 150, 16'd2000);
		send_peak(1'b1, pos + 180, 16'd0);
		pos += 300;
		send_peak(1'b0, pos, 16'd3200);
		send_peak(1'b1, pos - 10, 16'd100);
		send_peak(1'b0, pos + 5, 16'd4000);
		send_peak(1'b1, pos + 10, 16'hFFFF);
		send_peak(1'b1, pos + 200, 16'd900);
		pos += 300;
		send_peak(1'b1, pos, 16'd3100);
		send_peak(1'b1, pos + 400, 16'd1200);
		send_peak(1'b1, pos + 500, 16'd200);
		send_peak(1'b1, pos + 1200, 16'd100);
		send_peak(1'b1, pos + 1300, 16'd3000);
		pos += 1300;
		send_peak(1'b1, pos - 32'h8000_0000, 16'd3000);
		send_peak(1'b1, pos + 32'h7FFF_FFFF, 16'd0);
		pos += 32'h7FFF_FFFF;
		send_peak(1'b1, pos + 300, 16'd2500);
		pos += 300;

		// Pause the sender until every beat has come
		drain();

		// Random phases under several settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(REG_REFRACTORY, 16'hFFFF); write_reg(REG_COEFF, 16'd0); end
				1: begin write_reg(REG_REFRACTORY, 16'd1); write_reg(REG_COEFF, 16'hFFFF); end
				2: begin write_reg(REG_REFRACTORY, 16'($urandom_range(1, 200)));
					write_reg(REG_COEFF, 16'($urandom)); end
				default: begin write_reg(REG_REFRACTORY, 16'd72);
					write_reg(REG_COEFF, 16'd8716); end
			endcase
			if (ph == 4) quiet = 1'b1;
			beat_train(62, ph == 0 ? 70000 : int'($urandom_range(150, 400)),
				16'($urandom_range(500, 65535)), pos);
			// Bit coverage on items of random kind
			for (int j = 0; j < 10; j++) send_peak(1'($urandom), $urandom, 16'($urandom));
			drain();
		end

		if (error_count == 0 && tracker.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
